// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the conversion unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition never holds on any clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/f2h_pkg.sv =====
// ----------------------------------------------------------------------------
// f2h_pkg
// Shared constants for binary32 to binary16 saturating conversion.
// ----------------------------------------------------------------------------
`default_nettype none
package f2h_pkg;
	localparam logic [30:0] ABS_INF      = 31'h7F800000;
	localparam logic [30:0] MIN_NORM     = 31'h38800000;
	localparam logic [30:0] MAX_HALF     = 31'h477FE000;
	localparam logic [30:0] EXP_REBASE   = 31'h38000000;
	localparam logic [14:0] HALF_MIN_MAG = 15'h0400;
	localparam logic [14:0] HALF_MAX_MAG = 15'h7BFF;
	localparam logic [14:0] HALF_QNAN    = 15'h7E00;
endpackage
`default_nettype wire

// ===== rtl/core/f2h_single_if.sv =====
// ----------------------------------------------------------------------------
// f2h_single_if
// Valid/ready channel carrying one binary32 bit pattern.
// ----------------------------------------------------------------------------
`default_nettype none
interface f2h_single_if;
	logic        valid;
	logic        ready;
	logic [31:0] single_bits;
	modport source (output valid, output single_bits, input ready);
	modport sink (input valid, input single_bits, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/f2h_half_if.sv =====
// ----------------------------------------------------------------------------
// f2h_half_if
// Valid/ready channel carrying one binary16 bit pattern.
// ----------------------------------------------------------------------------
`default_nettype none
interface f2h_half_if;
	logic        valid;
	logic        ready;
	logic [15:0] half_bits;
	modport source (output valid, output half_bits, input ready);
	modport sink (input valid, input half_bits, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fp32_to_fp16_saturating_convert_unit.sv =====
// ----------------------------------------------------------------------------
// fp32_to_fp16_saturating_convert_unit
// Streaming binary32 to binary16 converter with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   in  : requests carrying a binary32 pattern (single_bits), valid/ready.
//   out : results carrying the binary16 pattern (half_bits), valid/ready.
//   Each request yields exactly one result. An input register feeds the
//   conversion logic, and a result register holds the answer; each
//   request passes through the input register, then the result register.
//   Throughput is one request per cycle: both registers advance together
//   whenever the result register is empty or being taken.
//   When the receiver stalls, both stages hold and in.ready drops once
//   both are full; nothing is lost.
//   Reset clears both valid flags; no clearing pass is needed.
//   Tiny nonzero magnitudes give the signed smallest normal; large ones
//   and infinities give the signed largest finite value; NaN stays quiet
//   NaN with its sign.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module fp32_to_fp16_saturating_convert_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	f2h_single_if.sink  in,
	f2h_half_if.source  out
);
	logic        valid_s1;
	logic [31:0] single_s1;
	logic        valid_s2;
	logic [15:0] half_s2;
	logic [15:0] half_c;
	logic        adv_s2;
	logic        adv_s1;

	// Advance when downstream slot is free
	assign adv_s2   = !valid_s2 || out.ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in.ready = adv_s1;

	f2h_convert u_convert (
		.single_bits(single_s1),
		.half_bits  (half_c)
	);

	// Hold valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in.valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (adv_s1 && in.valid) single_s1 <= in.single_bits;
		if (adv_s2 && valid_s1) half_s2 <= half_c;
	end

	assign out.valid     = valid_s2;
	assign out.half_bits = half_s2;

	`ASSERT_IMPL(a_stall_holds, clk, arst_n,
		(valid_s2 && !out.ready) |=> (valid_s2 && $stable(half_s2)),
		"result dropped during stall")
	`ASSERT_NEVER(a_full_blocks, clk, arst_n,
		valid_s1 && valid_s2 && !out.ready && in.ready,
		"accepted while full")
	`ASSERT_IMPL(a_stage_moves, clk, arst_n,
		(valid_s1 && adv_s2) |=> valid_s2,
		"stage one request lost")
endmodule
`default_nettype wire

// ===== rtl/core/f2h_convert.sv =====
// ----------------------------------------------------------------------------
// f2h_convert
// Combinational binary32 to binary16 conversion with saturation.
// ----------------------------------------------------------------------------
`default_nettype none
module f2h_convert (
	input  wire logic [31:0] single_bits,
	output logic      [15:0] half_bits
);
	logic        sign;
	logic [30:0] mag;
	logic [30:0] shifted;
	logic [14:0] trunc;
	logic [12:0] rem;
	logic        round_up;
	logic [14:0] mag_out;

	// Rebase exponent and round to nearest even
	always_comb begin
		sign     = single_bits[31];
		mag      = single_bits[30:0];
		shifted  = mag - f2h_pkg::EXP_REBASE;
		trunc    = shifted[27:13];
		rem      = shifted[12:0];
		round_up = (rem > 13'h1000) || ((rem == 13'h1000) && trunc[0]);
		if (mag > f2h_pkg::ABS_INF) begin
			mag_out = f2h_pkg::HALF_QNAN | {5'd0, 1'b0, mag[21:13]};
		end else if (mag == 31'd0) begin
			mag_out = 15'd0;
		end else if (mag < f2h_pkg::MIN_NORM) begin
			mag_out = f2h_pkg::HALF_MIN_MAG;
		end else if (mag > f2h_pkg::MAX_HALF) begin
			mag_out = f2h_pkg::HALF_MAX_MAG;
		end else begin
			mag_out = trunc + {14'd0, round_up};
		end
		half_bits = {sign, mag_out};
	end
endmodule
`default_nettype wire
